// ----- hdl/bace_pkg.sv -----
// Shared types, widths and constants of the barometric altitude / climb core.
// No dependencies; every other file of the block depends on this package.
package bace_pkg;

	localparam int CMD_W   = 2;
	localparam int PRESS_W = 23;
	localparam int TS_W    = 32;
	localparam int ALT_W   = 27;
	localparam int CLIMB_W = 21;
	localparam int CFG_W   = 16;
	localparam int LOG_W   = 21;   // 5 integer bits, 16 fraction bits
	localparam int ACC_W   = 31;   // Q30 mantissa below 2.0
	localparam int NUM_W   = 46;   // divider dividend
	localparam int DEN_W   = 32;   // divider divisor

	localparam int CAL_MAX_DEFAULT = 255;

	localparam logic [PRESS_W-1:0] GROUND_RESET       = 23'd6484800;
	localparam logic [CFG_W-1:0]   MIN_INTERVAL_RESET = 16'd1000;
	localparam logic [25:0]        ALT_SCALE          = 26'd44330000;
	localparam logic signed [33:0] ALT_MAX            = 34'sd44330000;
	localparam logic signed [33:0] ALT_MIN            = -34'sd10000000;
	localparam logic [19:0]        CLIMB_LIMIT        = 20'd1000000;
	localparam logic [14:0]        EXP_COEF           = 15'd12472;  // 0.1903 in Q16
	localparam logic [19:0]        US_PER_S           = 20'd1000000;

	typedef enum logic [CMD_W-1:0] {
		CMD_MEASURE    = 2'd0,
		CMD_CAL_SAMPLE = 2'd1,
		CMD_CAL_FINISH = 2'd2,
		CMD_SET_GROUND = 2'd3
	} cmd_t;

	typedef struct packed {
		logic             done;
		logic [LOG_W-1:0] log_q16;
	} log_res_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_res_t;

	// Elaboration-time integer square root, used only to build ROOT_TAB.
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] xv;
		r  = '0;
		b  = 64'd1 << 62;
		xv = x;
		while (b > xv)
			b = b >> 2;
		while (b != 0) begin
			if (xv >= r + b) begin
				xv = xv - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-k) in Q30, chained through truncating square roots.
	function automatic logic [ACC_W-1:0] root_factor(input int k);
		logic [63:0] a;
		a = 64'd1 << 31;
		for (int i = 1; i <= k; i++)
			a = isqrt64(a << 30);
		return a[ACC_W-1:0];
	endfunction

	localparam logic [ACC_W-1:0] ROOT_TAB [16] = '{
		root_factor(1),  root_factor(2),  root_factor(3),  root_factor(4),
		root_factor(5),  root_factor(6),  root_factor(7),  root_factor(8),
		root_factor(9),  root_factor(10), root_factor(11), root_factor(12),
		root_factor(13), root_factor(14), root_factor(15), root_factor(16)
	};

endpackage

// ----- hdl/bace_if.sv -----
// Valid/ready channel interfaces for the sample and result beats.
// Depends on bace_pkg for the field widths.
interface bace_in_if;
	logic                          valid;
	logic                          ready;
	logic [bace_pkg::CMD_W-1:0]    cmd;
	logic [bace_pkg::PRESS_W-1:0]  pressure;
	logic [bace_pkg::TS_W-1:0]     timestamp_us;

	modport source(output valid, cmd, pressure, timestamp_us, input ready);
	modport sink(input valid, cmd, pressure, timestamp_us, output ready);
endinterface

interface bace_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bace_pkg::ALT_W-1:0]   altitude_mm;
	logic signed [bace_pkg::CLIMB_W-1:0] climb_mm_s;
	logic                                climb_updated;
	logic                                ground_changed;

	modport source(output valid, altitude_mm, climb_mm_s, climb_updated, ground_changed,
		input ready);
	modport sink(input valid, altitude_mm, climb_mm_s, climb_updated, ground_changed,
		output ready);
endinterface

// ----- hdl/bace_log2.sv -----
// Serial log2 in Q16: one fraction bit per cycle by squaring the Q30 mantissa.
// Depends on bace_pkg.
module bace_log2 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bace_pkg::PRESS_W-1:0] value,
	output bace_pkg::log_res_t           res
);
	import bace_pkg::*;

	logic [ACC_W-1:0]   m_q;
	logic [LOG_W-1:0]   r_q;
	logic [3:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [4:0]         msb;
	logic [2*ACC_W-1:0] sq;
	logic [ACC_W:0]     m2;

	always_comb begin
		msb = '0;
		for (int i = 0; i < PRESS_W; i++)
			if (value[i]) msb = 5'(i);
		sq = (2*ACC_W)'(m_q) * (2*ACC_W)'(m_q);
		m2 = sq[2*ACC_W-1:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				m_q    <= ACC_W'(value) << (5'd30 - msb);
				r_q    <= {msb, 16'd0};
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// next fraction bit shifts in at the bottom
				r_q[15:0] <= {r_q[14:0], m2[ACC_W]};
				m_q       <= m2[ACC_W] ? m2[ACC_W:1] : m2[ACC_W-1:0];
				cnt_q     <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done    = done_q;
	assign res.log_q16 = r_q;

endmodule

// ----- hdl/bace_sdiv.sv -----
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on bace_pkg.
module bace_sdiv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bace_pkg::NUM_W-1:0] num,
	input  logic [bace_pkg::DEN_W-1:0] den,
	output bace_pkg::div_res_t         res
);
	import bace_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] nq_q;   // dividend shifts out, quotient shifts in
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             qbit;

	always_comb begin
		trial = {rem_q, nq_q[NUM_W-1]};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				nq_q   <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
				nq_q  <= {nq_q[NUM_W-2:0], qbit};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = nq_q;

endmodule

// ----- hdl/baro_altitude_climb_estimator_core.sv -----
// Top level of the barometric altitude and climb-rate core.
// Depends on bace_pkg, bace_if, bace_log2 and bace_sdiv.
//
// Usage:
//  - sample: valid/ready beat of {cmd, pressure (1/64 Pa), timestamp_us}.
//    cmd measure turns pressure into altitude above the ground reference
//    and refreshes climb when more than min_interval_us has elapsed;
//    cal sample accumulates, cal finish loads the rounded mean as ground,
//    set ground loads pressure directly.
//  - result: one beat per sample beat, held in an output register.
//  - APB: register 0 (byte address 0) is min_interval_us, reset 1000.
// Flow, from the accepting edge to result.valid: a measure beat runs two
//   serial log2 passes (pressure, then ground), the serial power product,
//   the shift-add scale and the sequencer steps between them, and a serial
//   divide when climb is refreshed against history. Cal finish with samples
//   runs the serial divide; every other beat goes straight to the output
//   step. sample.ready rises with result.valid, so one beat is worked at a
//   time.
// A new sample is taken while the previous result still waits; if the
// receiver stalls, the finished beat waits in its state until the output
// register frees. Reset restores ground 101325 Pa and clears history.
module baro_altitude_climb_estimator_core #(
	parameter int CAL_MAX_SAMPLES = bace_pkg::CAL_MAX_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	bace_in_if.sink     sample,
	bace_out_if.source  result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bace_pkg::*;

	localparam int CNT_W = $clog2(CAL_MAX_SAMPLES + 1);
	localparam int SUM_W = PRESS_W + CNT_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOGP, ST_LOGG, ST_EXP, ST_POW, ST_ABS, ST_MUL,
		ST_ALT, ST_DIFF, ST_CLIMB, ST_DIV, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [CFG_W-1:0] min_q;

	// estimator state
	logic [PRESS_W-1:0]        ground_q;
	logic signed [ALT_W-1:0]   prev_alt_q;
	logic [TS_W-1:0]           prev_time_q;
	logic signed [CLIMB_W-1:0] held_q;
	logic                      have_prev_q;
	logic [SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]          cnt_q;

	// working registers of the current beat
	cmd_t                    cmd_q;
	logic [PRESS_W-1:0]      p_q;
	logic [TS_W-1:0]         ts_q;
	logic [LOG_W-1:0]        lp_q;
	logic signed [LOG_W:0]   d_q;
	logic signed [36:0]      e_q;
	logic [15:0]             fsh_q;
	logic [ACC_W-1:0]        acc_q;
	logic [4:0]              step_q;
	logic [61:0]             mcand_q;
	logic [61:0]             prod_q;
	logic                    tsign_q;
	logic signed [ALT_W-1:0] alt_q;
	logic [25:0]             absd_q;
	logic                    dsign_q;
	logic                    upd_q;
	logic                    gch_q;
	logic [NUM_W-1:0]        num_q;
	logic [DEN_W-1:0]        den_q;
	logic                    log_start_q;
	logic                    div_start_q;

	// output register
	logic                      res_valid_q;
	logic signed [ALT_W-1:0]   res_alt_q;
	logic signed [CLIMB_W-1:0] res_climb_q;
	logic                      res_upd_q;
	logic                      res_gch_q;

	log_res_t           log_res;
	div_res_t           div_res;
	logic [PRESS_W-1:0] log_val;

	bace_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start_q),
		.value  (log_val),
		.res    (log_res)
	);

	bace_sdiv u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den_q),
		.res    (div_res)
	);

	assign log_val = (state_q == ST_LOGG) ? ground_q : p_q;

	// datapath between the sequencer steps
	logic signed [36:0]   e_next;
	logic [61:0]          root_prod;
	logic signed [4:0]    ip;
	logic [4:0]           nip;
	logic [35:0]          pw;
	logic signed [36:0]   t;
	logic [35:0]          mag;
	logic [61:0]          rnd;
	logic [31:0]          q;
	logic signed [33:0]   alt_raw;
	logic signed [ALT_W-1:0] alt_fin;
	logic signed [ALT_W:0] diff;
	logic [TS_W-1:0]      dt;
	logic                 upd;
	logic [19:0]          qsat;
	logic signed [CLIMB_W-1:0] climb_new;

	always_comb begin
		e_next    = 37'(d_q) * $signed({22'd0, EXP_COEF});
		root_prod = 62'(acc_q) * 62'(ROOT_TAB[step_q[3:0]]);

		// 2^y = 2^frac shifted by floor(y), then 1 - 2^y in Q30
		ip  = e_q[36:32];
		nip = 5'(-ip);
		pw  = ip[4] ? (36'(acc_q) >> nip) : (36'(acc_q) << ip[2:0]);
		t   = 37'sd1073741824 - $signed({1'b0, pw});
		mag = t[36] ? 36'(-t) : 36'(t);

		// round half up on the magnitude, then restore sign and clamp
		rnd     = prod_q + 62'd536870912;
		q       = rnd[61:30];
		alt_raw = tsign_q ? -$signed({2'b00, q}) : $signed({2'b00, q});
		if (ground_q == '0)
			alt_fin = ALT_W'(ALT_MIN);
		else if (p_q == '0)
			alt_fin = ALT_W'(ALT_MAX);
		else if (alt_raw < ALT_MIN)
			alt_fin = ALT_W'(ALT_MIN);
		else if (alt_raw > ALT_MAX)
			alt_fin = ALT_W'(ALT_MAX);
		else
			alt_fin = ALT_W'(alt_raw);

		diff = $signed({alt_q[ALT_W-1], alt_q}) - $signed({prev_alt_q[ALT_W-1], prev_alt_q});
		dt   = ts_q - prev_time_q;
		upd  = dt > TS_W'(min_q);

		qsat = (div_res.quot > NUM_W'(CLIMB_LIMIT)) ? CLIMB_LIMIT : div_res.quot[19:0];
		climb_new = dsign_q ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
	end

	// APB register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_INTERVAL_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			min_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : 32'(min_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ground_q    <= GROUND_RESET;
			prev_alt_q  <= '0;
			prev_time_q <= '0;
			held_q      <= '0;
			have_prev_q <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			log_start_q <= 1'b0;
			div_start_q <= 1'b0;
			res_valid_q <= 1'b0;
			upd_q       <= 1'b0;
			gch_q       <= 1'b0;
			step_q      <= '0;
		end else begin
			log_start_q <= 1'b0;
			div_start_q <= 1'b0;
			// ST_DONE refills the output register itself
			if (result.ready && state_q != ST_DONE)
				res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						cmd_q <= cmd_t'(sample.cmd);
						p_q   <= sample.pressure;
						ts_q  <= sample.timestamp_us;
						upd_q <= 1'b0;
						gch_q <= 1'b0;
						case (cmd_t'(sample.cmd))
							CMD_MEASURE: begin
								log_start_q <= 1'b1;
								state_q     <= ST_LOGP;
							end
							CMD_CAL_SAMPLE: begin
								if (cnt_q < CNT_W'(CAL_MAX_SAMPLES)) begin
									sum_q <= sum_q + SUM_W'(sample.pressure);
									cnt_q <= cnt_q + 1'b1;
								end
								state_q <= ST_DONE;
							end
							CMD_CAL_FINISH: begin
								if (cnt_q != '0) begin
									num_q       <= NUM_W'(sum_q + SUM_W'(cnt_q >> 1));
									den_q       <= DEN_W'(cnt_q);
									div_start_q <= 1'b1;
									state_q     <= ST_DIV;
								end else begin
									sum_q   <= '0;
									state_q <= ST_DONE;
								end
							end
							CMD_SET_GROUND: begin
								ground_q <= sample.pressure;
								gch_q    <= 1'b1;
								state_q  <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOGP: begin
					if (log_res.done) begin
						lp_q        <= log_res.log_q16;
						log_start_q <= 1'b1;
						state_q     <= ST_LOGG;
					end
				end
				ST_LOGG: begin
					if (log_res.done) begin
						d_q     <= $signed({1'b0, lp_q}) - $signed({1'b0, log_res.log_q16});
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					e_q     <= e_next;
					fsh_q   <= e_next[31:16];
					acc_q   <= ACC_W'(1) << 30;
					step_q  <= '0;
					state_q <= ST_POW;
				end
				ST_POW: begin
					// one fraction bit of the exponent per cycle
					if (fsh_q[15])
						acc_q <= root_prod[60:30];
					fsh_q  <= {fsh_q[14:0], 1'b0};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd15)
						state_q <= ST_ABS;
				end
				ST_ABS: begin
					mcand_q <= 62'(mag);
					tsign_q <= t[36];
					prod_q  <= '0;
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// shift-add by the 44330000 mm scale, one bit per cycle
					if (ALT_SCALE[step_q])
						prod_q <= prod_q + mcand_q;
					mcand_q <= {mcand_q[60:0], 1'b0};
					step_q  <= step_q + 5'd1;
					if (step_q == 5'd25)
						state_q <= ST_ALT;
				end
				ST_ALT: begin
					alt_q   <= alt_fin;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					dsign_q <= diff[ALT_W];
					absd_q  <= diff[ALT_W] ? 26'(-diff) : 26'(diff);
					upd_q   <= upd;
					state_q <= ST_CLIMB;
				end
				ST_CLIMB: begin
					if (!upd_q) begin
						state_q <= ST_DONE;
					end else if (!have_prev_q) begin
						// first refresh reports zero climb
						held_q      <= '0;
						prev_alt_q  <= alt_q;
						prev_time_q <= ts_q;
						have_prev_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						num_q       <= NUM_W'(absd_q) * NUM_W'(US_PER_S);
						den_q       <= dt;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						if (cmd_q == CMD_CAL_FINISH) begin
							ground_q <= div_res.quot[PRESS_W-1:0];
							gch_q    <= 1'b1;
							sum_q    <= '0;
							cnt_q    <= '0;
						end else begin
							held_q      <= climb_new;
							prev_alt_q  <= alt_q;
							prev_time_q <= ts_q;
							have_prev_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_alt_q   <= (cmd_q == CMD_MEASURE) ? alt_q : prev_alt_q;
						res_climb_q <= held_q;
						res_upd_q   <= upd_q;
						res_gch_q   <= gch_q;
						res_valid_q <= 1'b1;
						if (cmd_q == CMD_CAL_FINISH)
							cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample.ready          = (state_q == ST_IDLE);
	assign result.valid          = res_valid_q;
	assign result.altitude_mm    = res_alt_q;
	assign result.climb_mm_s     = res_climb_q;
	assign result.climb_updated  = res_upd_q;
	assign result.ground_changed = res_gch_q;

	// a climb refresh only comes from a measure beat, never with a ground load
	a_upd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.climb_updated |-> !result.ground_changed)
		else $error("climb refresh together with ground load");

	a_upd_hist: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.climb_updated |-> have_prev_q)
		else $error("climb refreshed without history");

	a_climb_rng: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.climb_mm_s <= 21'sd1000000) &&
		(result.climb_mm_s >= -21'sd1000000))
		else $error("climb out of range");

	a_alt_rng: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.altitude_mm <= 27'sd44330000) &&
		(result.altitude_mm >= -27'sd10000000))
		else $error("altitude out of range");

endmodule
